[rtl/negative_base_converter_unit_defines.svh]
// Assertion macros for the converter RTL.
`ifndef NEGATIVE_BASE_CONVERTER_UNIT_DEFINES_SVH
`define NEGATIVE_BASE_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nbc assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define NBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nbc assertion failed");

`endif

[rtl/nbc_pkg.sv]
`default_nettype none
package nbc_pkg;

  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [DIGIT_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX      = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_RESET    = 6'd2;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0]  ALPHA_OFFSET   = 7'd55;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    return (d < DECIMAL_DIGITS) ? dx + CHAR_ZERO : dx + ALPHA_OFFSET;
  endfunction

  function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] m);
    logic [DIGIT_W-1:0] r;
    r = m;
    if (m < RADIX_MIN) r = RADIX_MIN;
    else if (m > RADIX_MAX) r = RADIX_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/nbc_ram.sv]
`default_nettype none
module nbc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/nbc_div.sv]
`default_nettype none
module nbc_div #(
  parameter int DW = 33
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [nbc_pkg::DIGIT_W-1:0] divisor,
  output logic                        done,
  output logic [DW-1:0]               quotient,
  output logic [nbc_pkg::DIGIT_W-1:0] remainder
);
  import nbc_pkg::*;

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0]      quo;
  logic [DIGIT_W-1:0] rem;
  logic [NW-1:0]      cnt;
  logic               running;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   diff;
  logic               ge;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= NW'(DW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

[rtl/negative_base_converter_unit.sv]
`default_nettype none
// Negative base converter: writes a signed value in base -M as ASCII digits.
// Config: radix_we/radix_data set the magnitude M (values below 2 act as 2,
//   above 36 as 36); write it only while busy is low. Reset value is 2.
// Input: value is taken at a clock edge with start high and busy low.
// Output: one word per digit, most significant first, on digit_char with
//   valid high for exactly one cycle; last marks the least significant digit.
//   Words of one number come on consecutive cycles. Zero gives a single '0'.
// Flow: each digit takes one pass of the shared restoring divider over
//   VALUE_WIDTH+1 quotient bits plus a step through S_CHECK; readout from
//   the digit RAM follows. Busy stays high from acceptance until the last
//   word is out, so one number is in flight at a time.
// At most MAX_DIGITS low digits are kept; higher ones are dropped.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
//   number in progress; the digit RAM needs no clearing.
// The receiver cannot stall: every word must be taken in its cycle.
module negative_base_converter_unit #(
  parameter int MAX_DIGITS  = 34,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                        radix_we,
  input  logic [nbc_pkg::DIGIT_W-1:0] radix_data,
  output logic                        valid,
  output logic [nbc_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last
);
  import nbc_pkg::*;
  `include "negative_base_converter_unit_defines.svh"

  localparam int RW = VALUE_WIDTH + 1;
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  state_t                state;
  logic [DIGIT_W-1:0]    radix_magnitude;
  logic [DIGIT_W-1:0]    m;
  logic signed [RW-1:0]  remaining;
  logic [CW-1:0]         digit_count;
  logic [CW-1:0]         rd_idx;
  logic                  pend;
  logic                  pend_last;

  logic                  neg;
  logic [RW-1:0]         mag;
  logic                  div_start;
  logic                  div_done;
  logic [RW-1:0]         uq;
  logic [DIGIT_W-1:0]    ur;
  logic [DIGIT_W-1:0]    digit;
  logic signed [RW-1:0]  remaining_next;
  logic                  more;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DIGIT_W-1:0]    ram_wdata;
  logic [DIGIT_W-1:0]    ram_rdata;

  assign m    = clamp_radix(radix_magnitude);
  assign neg  = remaining[RW-1];
  assign mag  = neg ? RW'(-remaining) : RW'(remaining);
  assign more = (remaining != '0) && (digit_count < CW'(MAX_DIGITS));
  assign div_start = (state == S_CHECK) && more;

  // negabase rule: non-negative digit, quotient adjusted on negative values
  always_comb begin
    if (neg) begin
      digit          = (ur != '0) ? m - ur : '0;
      remaining_next = $signed(uq + RW'(ur != '0));
    end else begin
      digit          = ur;
      remaining_next = $signed(RW'(-uq));
    end
  end

  nbc_div #(.DW(RW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (m),
    .done      (div_done),
    .quotient  (uq),
    .remainder (ur)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = digit_count[AW-1:0];
    ram_wdata = digit;
    if (state == S_CHECK && remaining == '0 && digit_count == '0) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (state == S_DIV && div_done) begin
      ram_we = 1'b1;
    end
  end

  nbc_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE) || pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      radix_magnitude <= RADIX_RESET;
      remaining       <= '0;
      digit_count     <= '0;
      rd_idx          <= '0;
      pend            <= 1'b0;
      pend_last       <= 1'b0;
      valid           <= 1'b0;
      last            <= 1'b0;
    end else begin
      if (radix_we) begin
        radix_magnitude <= radix_data;
      end
      pend  <= 1'b0;
      valid <= pend;
      last  <= pend && pend_last;
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            remaining   <= RW'(value);
            digit_count <= '0;
            state       <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (more) begin
            state <= S_DIV;
          end else begin
            if (digit_count == '0) begin
              digit_count <= CW'(1);
              rd_idx      <= '0;
            end else begin
              rd_idx <= digit_count - 1'b1;
            end
            state <= S_READ;
          end
        end
        S_DIV: begin
          if (div_done) begin
            remaining   <= remaining_next;
            digit_count <= digit_count + 1'b1;
            state       <= S_CHECK;
          end
        end
        S_READ: begin
          pend      <= 1'b1;
          pend_last <= (rd_idx == '0);
          if (rd_idx == '0) begin
            state <= S_IDLE;
          end else begin
            rd_idx <= rd_idx - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      digit_char <= digit_to_char(ram_rdata);
    end
  end

  `NBC_ASSERT_NEXT(a_accept_starts, start && !busy, state == S_CHECK)
  `NBC_ASSERT_NEXT(a_words_back_to_back, valid && !last, valid)
  `NBC_ASSERT_SAME(a_count_bound, 1'b1, digit_count <= CW'(MAX_DIGITS))
  `NBC_ASSERT_SAME(a_div_nonzero, state == S_DIV, remaining != '0)
  `NBC_ASSERT_SAME(a_valid_in_readout, valid, state == S_READ || state == S_IDLE)

endmodule
`default_nettype wire
